>>> sv/abf_pkg.sv
package abf_pkg;

  localparam int OP_W  = 3;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_SET   = 3'd0;
  localparam logic [OP_W-1:0] OP_RESET = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_NONE  = 2'd2;

  localparam logic [CNT_W-1:0] USED_BITS_RESET = 13'd4096;

endpackage

>>> sv/abf_if.sv
interface abf_req_if;
  logic                       valid;
  logic                       ready;
  logic [abf_pkg::OP_W-1:0]   operation;
  logic [abf_pkg::IDX_W-1:0]  index;

  modport source (output valid, output operation, output index, input ready);
  modport sink (input valid, input operation, input index, output ready);
endinterface

interface abf_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [abf_pkg::ST_W-1:0]   status;
  logic                       bit_value;
  logic [abf_pkg::IDX_W-1:0]  found_index;

  modport source (output valid, output status, output bit_value, output found_index,
                  input ready);
  modport sink (input valid, input status, input bit_value, input found_index,
                output ready);
endinterface

interface abf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [abf_pkg::CNT_W-1:0]  used_bits;

  modport source (output valid, output used_bits, input ready);
  modport sink (input valid, input used_bits, output ready);
endinterface

>>> sv/allocation_bitmap_find_first_free_unit.sv
// Set, reset and test pass S_DIV, S_ADDR and S_MOD; set and reset read-modify-write a word.
// An index out of range is answered from S_DIV and an unused operation code from S_IDLE.
// Clear writes all WORD_COUNT memory words, one memory word per cycle.
// Find reads and checks the words in turn until one has a free bit or the used range or map ends.
// One request is in work at a time; the next is taken once the result is queued.
// After reset the map is cleared in one pass during which no request is taken.
module allocation_bitmap_find_first_free_unit #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input logic       clk,
  input logic       rst,
  abf_req_if.sink   req,
  abf_rsp_if.source rsp,
  abf_cfg_if.sink   cfg
);
  import abf_pkg::*;

  localparam int CAP = WORD_BITS * WORD_COUNT;
  localparam logic [CNT_W-1:0] CAP_CLAMP = CNT_W'((CAP > 8191) ? 8191 : CAP);
  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CW = $clog2(WORD_COUNT + 1);
  localparam int BW = $clog2(WORD_BITS);
  localparam int POS_W = 17;
  localparam logic [16:0] RECIP = 17'(((1 << 19) + WORD_BITS - 1) / WORD_BITS);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CLR  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_ADDR = 9'b000001000,
    S_MOD  = 9'b000010000,
    S_FRD  = 9'b000100000,
    S_FCHK = 9'b001000000,
    S_FPOS = 9'b010000000,
    S_PUSH = 9'b100000000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     used_bits;
  logic [CNT_W-1:0]     limit;
  logic [OP_W-1:0]      op_r;
  logic [IDX_W-1:0]     idx_r;
  logic [28:0]          prod;
  logic [9:0]           quot;
  logic [IDX_W-1:0]     word_base;
  logic [AW-1:0]        addr_r;
  logic [BW-1:0]        bitsel;
  logic [CW-1:0]        wcnt;
  logic [POS_W-1:0]     base;
  logic [POS_W-1:0]     pos;
  logic [BW-1:0]        fb;
  logic [BW-1:0]        enc;
  logic [WORD_BITS-1:0] iso;
  logic [WORD_BITS-1:0] mask;
  logic                 clr_push;

  logic [ST_W-1:0]      res_status;
  logic                 res_bit;
  logic [IDX_W-1:0]     res_found;
  logic                 out_valid;
  logic [ST_W-1:0]      out_status;
  logic                 out_bit;
  logic [IDX_W-1:0]     out_found;
  logic                 out_load;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_wa;
  logic [AW-1:0]        mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  assign limit     = (used_bits > CAP_CLAMP) ? CAP_CLAMP : used_bits;
  assign quot      = prod[28:19];
  assign word_base = IDX_W'({2'b00, quot} * IDX_W'(WORD_BITS));
  assign mask      = {{(WORD_BITS-1){1'b0}}, 1'b1} << bitsel;
  assign iso       = ~rdata & (rdata + {{(WORD_BITS-1){1'b0}}, 1'b1});
  assign pos       = base + POS_W'(fb);

  always_comb begin
    enc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        enc = enc | BW'(i);
      end
    end
  end

  always_comb begin
    mem_re = (state == S_ADDR) || (state == S_FRD);
    mem_ra = (state == S_ADDR) ? quot[AW-1:0] : wcnt[AW-1:0];
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = '0;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = wcnt[AW-1:0];
      end
      S_MOD: begin
        mem_we = (op_r == OP_SET) || (op_r == OP_RESET);
        mem_wd = (op_r == OP_SET) ? (rdata | mask) : (rdata & ~mask);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  assign out_load  = (state == S_PUSH) && (!out_valid || rsp.ready);
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      wcnt      <= '0;
      clr_push  <= 1'b0;
      used_bits <= USED_BITS_RESET;
    end else begin
      if (cfg.valid) begin
        used_bits <= cfg.used_bits;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r       <= req.operation;
            idx_r      <= req.index;
            res_status <= ST_OK;
            res_bit    <= 1'b0;
            res_found  <= '0;
            wcnt       <= '0;
            base       <= '0;
            clr_push   <= 1'b1;
            case (req.operation)
              OP_SET, OP_RESET, OP_TEST: state <= S_DIV;
              OP_CLEAR:                  state <= S_CLR;
              OP_FIND:                   state <= S_FRD;
              default:                   state <= S_PUSH;
            endcase
          end
        end
        S_CLR: begin
          wcnt <= wcnt + CW'(1);
          if (wcnt == CW'(WORD_COUNT - 1)) begin
            state <= clr_push ? S_PUSH : S_IDLE;
          end
        end
        S_DIV: begin
          prod <= 29'(idx_r) * 29'(RECIP);
          if ({1'b0, idx_r} >= limit) begin
            res_status <= ST_RANGE;
            state      <= S_PUSH;
          end else begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr_r <= quot[AW-1:0];
          bitsel <= BW'(idx_r - word_base);
          state  <= S_MOD;
        end
        S_MOD: begin
          if (op_r == OP_TEST) begin
            res_bit <= |(rdata & mask);
          end
          state <= S_PUSH;
        end
        S_FRD: begin
          if ((wcnt == CW'(WORD_COUNT)) || (base >= POS_W'(limit))) begin
            res_status <= ST_NONE;
            state      <= S_PUSH;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (&rdata) begin
            wcnt  <= wcnt + CW'(1);
            base  <= base + POS_W'(WORD_BITS);
            state <= S_FRD;
          end else begin
            fb    <= enc;
            state <= S_FPOS;
          end
        end
        S_FPOS: begin
          if (pos < POS_W'(limit)) begin
            res_found <= pos[IDX_W-1:0];
          end else begin
            res_status <= ST_NONE;
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_bit    <= res_bit;
      out_found  <= res_found;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.bit_value   = out_bit;
  assign rsp.found_index = out_found;

  a_fchk_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_FCHK) |-> ($past(state) == S_FRD))
    else $error("Word check without a preceding read.");

  a_fpos_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_FPOS) |-> (rdata != '1))
    else $error("Position taken from a full word.");

  a_mod_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> ({1'b0, idx_r} < limit))
    else $error("Map word modified for an index out of range.");

  a_range_only_indexed: assert property (@(posedge clk) disable iff (rst)
    (out_load && (res_status == ST_RANGE)) |->
      ((op_r == OP_SET) || (op_r == OP_RESET) || (op_r == OP_TEST)))
    else $error("Range status for an operation without an index.");

  a_bit_only_test: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_bit) |-> (op_r == OP_TEST))
    else $error("Bit value set for an operation other than test.");

endmodule
